[src/ata_identify_word_parser_core_defines.svh]
// assertion macros for the identify word parser
// needs clk and rst_n in the scope where a macro is used
`ifndef ATA_IDENTIFY_WORD_PARSER_CORE_DEFINES_SVH
`define ATA_IDENTIFY_WORD_PARSER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define AIWP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define AIWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/aiwp_pkg.sv]
// shared types and constants of the identify word parser
// used by aiwp_word_decode and ata_identify_word_parser_core
package aiwp_pkg;

    // word positions inside the identify block
    localparam logic [7:0] IDX_RESTART        = 8'd0;
    localparam logic [7:0] IDX_SERIAL_FIRST   = 8'd10;
    localparam logic [7:0] IDX_SERIAL_LAST    = 8'd19;
    localparam logic [7:0] IDX_FIRMWARE_FIRST = 8'd23;
    localparam logic [7:0] IDX_FIRMWARE_LAST  = 8'd26;
    localparam logic [7:0] IDX_MODEL_FIRST    = 8'd27;
    localparam logic [7:0] IDX_MODEL_LAST     = 8'd46;
    localparam logic [7:0] IDX_LEGACY_LO      = 8'd60;
    localparam logic [7:0] IDX_LEGACY_HI      = 8'd61;
    localparam logic [7:0] IDX_FEAT_SUPPORT   = 8'd83;
    localparam logic [7:0] IDX_FEAT_ENABLED   = 8'd86;
    localparam logic [7:0] IDX_EXT_CAP_FIRST  = 8'd100;
    localparam logic [7:0] IDX_EXT_CAP_LAST   = 8'd103;
    localparam logic [7:0] IDX_SECTOR_FMT     = 8'd106;
    localparam logic [7:0] IDX_LSIZE_LO       = 8'd117;
    localparam logic [7:0] IDX_LSIZE_HI       = 8'd118;
    localparam logic [7:0] IDX_DONE           = 8'd255;

    // bit positions in the feature and sector format words
    localparam int LBA48_BIT     = 10;
    localparam int FMT_VALID_BIT = 14;
    localparam int FMT_RSVD_BIT  = 15;
    localparam int FMT_LARGE_BIT = 12;

    // captured format bits {bit15, bit14, bit12}: logical size valid when 0,1,1
    localparam logic [2:0] FMT_LOGICAL_VALID = 3'b011;

    localparam logic [7:0]  SPACE_CHAR        = 8'h20;
    localparam logic [15:0] BASE_SECTOR_RESET = 16'd512;

    localparam logic [1:0] STR_NONE     = 2'd0;
    localparam logic [1:0] STR_SERIAL   = 2'd1;
    localparam logic [1:0] STR_FIRMWARE = 2'd2;
    localparam logic [1:0] STR_MODEL    = 2'd3;

    localparam logic [4:0] SERIAL_MAX_LEN   = 5'd20;
    localparam logic [3:0] FIRMWARE_MAX_LEN = 4'd8;
    localparam logic [5:0] MODEL_MAX_LEN    = 6'd40;

    typedef enum logic [3:0] {
        KIND_OTHER,
        KIND_RESTART,
        KIND_SERIAL,
        KIND_FIRMWARE,
        KIND_MODEL,
        KIND_LEGACY_LO,
        KIND_LEGACY_HI,
        KIND_FEAT_SUPPORT,
        KIND_FEAT_ENABLED,
        KIND_EXT_CAP,
        KIND_SECTOR_FMT,
        KIND_LSIZE_LO,
        KIND_LSIZE_HI,
        KIND_DONE
    } word_kind_t;

    typedef struct packed {
        word_kind_t kind;
        logic [1:0] string_id;
        logic [5:0] char_position;
        logic [5:0] cand_len;      // last non-space position plus one within this word
        logic [1:0] ext_lane;      // which 16-bit lane of the 64-bit capacity
    } word_dec_t;

endpackage

[src/ata_identify_word_parser_core.sv]
// top level of the identify word parser: state capture and result register
// depends on aiwp_pkg, aiwp_word_decode and ata_identify_word_parser_core_defines.svh
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  input   | in_valid, in_stall | data_word, word_index
//  result  | out_valid,         | string_id, first_char, second_char,
//          | out_stall          | char_position, block_done, capacity_sectors,
//          |                    | sector_bytes, lba48_flag, model_length,
//          |                    | serial_length, firmware_length
//  config  | cfg_we             | cfg_wdata (base sector size)
//
//  one beat per cycle while in_stall is low; a result shows up in the cycle after its word is taken
//  decode and state update sit between the input port and the result register
//  in_stall rises only while a held result is stalled on the output
//  rst_n clears all captured state, sets the base size to 512, empties the output
`include "ata_identify_word_parser_core_defines.svh"

module ata_identify_word_parser_core
    import aiwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] data_word,
    input  logic [7:0]  word_index,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  string_id,
    output logic [7:0]  first_char,
    output logic [7:0]  second_char,
    output logic [5:0]  char_position,
    output logic        block_done,
    output logic [63:0] capacity_sectors,
    output logic [31:0] sector_bytes,
    output logic        lba48_flag,
    output logic [5:0]  model_length,
    output logic [4:0]  serial_length,
    output logic [3:0]  firmware_length
);

    word_dec_t   dec;
    logic        in_accept;
    logic        out_accept;

    logic [15:0] base_sector_reg;
    logic [31:0] legacy_cap_reg,   legacy_cap_next;
    logic [63:0] ext_cap_reg,      ext_cap_next;
    logic [1:0]  lba48_bits_reg,   lba48_bits_next;
    logic [2:0]  fmt_bits_reg,     fmt_bits_next;
    logic [31:0] lsize_reg,        lsize_next;
    logic [5:0]  model_len_reg,    model_len_next;
    logic [4:0]  serial_len_reg,   serial_len_next;
    logic [3:0]  firmware_len_reg, firmware_len_next;

    logic        out_valid_reg,    out_valid_next;
    logic [1:0]  string_id_reg;
    logic [7:0]  first_char_reg;
    logic [7:0]  second_char_reg;
    logic [5:0]  char_position_reg;
    logic        block_done_reg;
    logic [63:0] capacity_reg;
    logic [31:0] sector_bytes_reg;
    logic        lba48_flag_reg;
    logic [5:0]  model_length_reg;
    logic [4:0]  serial_length_reg;
    logic [3:0]  firmware_length_reg;

    logic        big_drive;
    logic [63:0] capacity_next;
    logic [31:0] sector_bytes_next;

    aiwp_word_decode u_decode (
        .data_word  (data_word),
        .word_index (word_index),
        .dec        (dec)
    );

    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_accept = out_valid_reg & ~out_stall;

    // captured state
    always_comb
    begin
        legacy_cap_next   = legacy_cap_reg;
        ext_cap_next      = ext_cap_reg;
        lba48_bits_next   = lba48_bits_reg;
        fmt_bits_next     = fmt_bits_reg;
        lsize_next        = lsize_reg;
        model_len_next    = model_len_reg;
        serial_len_next   = serial_len_reg;
        firmware_len_next = firmware_len_reg;
        case (dec.kind)
            KIND_RESTART:
            begin
                legacy_cap_next   = '0;
                ext_cap_next      = '0;
                lba48_bits_next   = '0;
                fmt_bits_next     = '0;
                lsize_next        = '0;
                model_len_next    = '0;
                serial_len_next   = '0;
                firmware_len_next = '0;
            end
            KIND_SERIAL:
                if (dec.cand_len > {1'b0, serial_len_reg})
                    serial_len_next = dec.cand_len[4:0];
            KIND_FIRMWARE:
                if (dec.cand_len > {2'b00, firmware_len_reg})
                    firmware_len_next = dec.cand_len[3:0];
            KIND_MODEL:
                if (dec.cand_len > model_len_reg)
                    model_len_next = dec.cand_len;
            KIND_LEGACY_LO:    legacy_cap_next[15:0]  = data_word;
            KIND_LEGACY_HI:    legacy_cap_next[31:16] = data_word;
            KIND_FEAT_SUPPORT: lba48_bits_next[0]     = data_word[LBA48_BIT];
            KIND_FEAT_ENABLED: lba48_bits_next[1]     = data_word[LBA48_BIT];
            KIND_EXT_CAP:      ext_cap_next[{dec.ext_lane, 4'b0000} +: 16] = data_word;
            KIND_SECTOR_FMT:
                fmt_bits_next = {data_word[FMT_RSVD_BIT], data_word[FMT_VALID_BIT],
                                 data_word[FMT_LARGE_BIT]};
            KIND_LSIZE_LO:     lsize_next[15:0]  = data_word;
            KIND_LSIZE_HI:     lsize_next[31:16] = data_word;
            default:
            begin
            end
        endcase
    end

    // summary values, used only on the completion beat
    assign big_drive         = &lba48_bits_reg;
    assign capacity_next     = big_drive ? ext_cap_reg : {32'd0, legacy_cap_reg};
    assign sector_bytes_next = (fmt_bits_reg == FMT_LOGICAL_VALID) ?
                               {lsize_reg[30:0], 1'b0} : {16'd0, base_sector_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_accept)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_sector_reg  <= BASE_SECTOR_RESET;
            legacy_cap_reg   <= '0;
            ext_cap_reg      <= '0;
            lba48_bits_reg   <= '0;
            fmt_bits_reg     <= '0;
            lsize_reg        <= '0;
            model_len_reg    <= '0;
            serial_len_reg   <= '0;
            firmware_len_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                base_sector_reg <= cfg_wdata;
            if (in_accept)
            begin
                legacy_cap_reg   <= legacy_cap_next;
                ext_cap_reg      <= ext_cap_next;
                lba48_bits_reg   <= lba48_bits_next;
                fmt_bits_reg     <= fmt_bits_next;
                lsize_reg        <= lsize_next;
                model_len_reg    <= model_len_next;
                serial_len_reg   <= serial_len_next;
                firmware_len_reg <= firmware_len_next;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            string_id_reg     <= dec.string_id;
            char_position_reg <= dec.char_position;
            if (dec.string_id != STR_NONE)
            begin
                first_char_reg  <= data_word[15:8];
                second_char_reg <= data_word[7:0];
            end
            else
            begin
                first_char_reg  <= '0;
                second_char_reg <= '0;
            end
            if (dec.kind == KIND_DONE)
            begin
                block_done_reg      <= 1'b1;
                capacity_reg        <= capacity_next;
                sector_bytes_reg    <= sector_bytes_next;
                lba48_flag_reg      <= big_drive;
                model_length_reg    <= model_len_reg;
                serial_length_reg   <= serial_len_reg;
                firmware_length_reg <= firmware_len_reg;
            end
            else
            begin
                block_done_reg      <= 1'b0;
                capacity_reg        <= '0;
                sector_bytes_reg    <= '0;
                lba48_flag_reg      <= 1'b0;
                model_length_reg    <= '0;
                serial_length_reg   <= '0;
                firmware_length_reg <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign string_id        = string_id_reg;
    assign first_char       = first_char_reg;
    assign second_char      = second_char_reg;
    assign char_position    = char_position_reg;
    assign block_done       = block_done_reg;
    assign capacity_sectors = capacity_reg;
    assign sector_bytes     = sector_bytes_reg;
    assign lba48_flag       = lba48_flag_reg;
    assign model_length     = model_length_reg;
    assign serial_length    = serial_length_reg;
    assign firmware_length  = firmware_length_reg;

    `AIWP_ASSERT_NEXT(a_beat_gives_result, in_accept, out_valid_reg,
        "accepted word did not produce a result")
    `AIWP_ASSERT_NEXT(a_restart_clears, in_accept && word_index == IDX_RESTART,
        model_len_reg == '0 && serial_len_reg == '0 && firmware_len_reg == '0
        && lba48_bits_reg == '0 && fmt_bits_reg == '0,
        "restart word did not clear captured state")
    `AIWP_ASSERT_SAME(a_summary_only_on_done, out_valid_reg && !block_done_reg,
        capacity_reg == '0 && sector_bytes_reg == '0 && !lba48_flag_reg,
        "summary fields set on a non-completion result")
    `AIWP_ASSERT_SAME(a_no_string_no_chars, out_valid_reg && string_id_reg == STR_NONE,
        first_char_reg == '0 && second_char_reg == '0 && char_position_reg == '0,
        "characters reported on a non-string word")
    `AIWP_ASSERT_SAME(a_len_bounds, 1'b1,
        serial_len_reg <= SERIAL_MAX_LEN && firmware_len_reg <= FIRMWARE_MAX_LEN
        && model_len_reg <= MODEL_MAX_LEN,
        "trimmed length beyond string size")

endmodule

[src/aiwp_word_decode.sv]
// classifies one identify word by its index and works out string position
// and the candidate trimmed length; depends on aiwp_pkg
module aiwp_word_decode
    import aiwp_pkg::*;
(
    input  logic [15:0] data_word,
    input  logic [7:0]  word_index,
    output word_dec_t   dec
);

    logic [7:0] str_base;
    logic [7:0] str_offset;
    logic [7:0] ext_offset;
    logic [7:0] hi_char;
    logic [7:0] lo_char;
    logic [5:0] pos;

    assign hi_char    = data_word[15:8];
    assign lo_char    = data_word[7:0];
    assign ext_offset = word_index - IDX_EXT_CAP_FIRST;

    always_comb
    begin
        dec          = '0;
        dec.kind     = KIND_OTHER;
        str_base     = IDX_SERIAL_FIRST;
        dec.ext_lane = ext_offset[1:0];
        unique case (word_index) inside
            IDX_RESTART:                         dec.kind = KIND_RESTART;
            [IDX_SERIAL_FIRST:IDX_SERIAL_LAST]:
            begin
                dec.kind      = KIND_SERIAL;
                dec.string_id = STR_SERIAL;
                str_base      = IDX_SERIAL_FIRST;
            end
            [IDX_FIRMWARE_FIRST:IDX_FIRMWARE_LAST]:
            begin
                dec.kind      = KIND_FIRMWARE;
                dec.string_id = STR_FIRMWARE;
                str_base      = IDX_FIRMWARE_FIRST;
            end
            [IDX_MODEL_FIRST:IDX_MODEL_LAST]:
            begin
                dec.kind      = KIND_MODEL;
                dec.string_id = STR_MODEL;
                str_base      = IDX_MODEL_FIRST;
            end
            IDX_LEGACY_LO:                       dec.kind = KIND_LEGACY_LO;
            IDX_LEGACY_HI:                       dec.kind = KIND_LEGACY_HI;
            IDX_FEAT_SUPPORT:                    dec.kind = KIND_FEAT_SUPPORT;
            IDX_FEAT_ENABLED:                    dec.kind = KIND_FEAT_ENABLED;
            [IDX_EXT_CAP_FIRST:IDX_EXT_CAP_LAST]: dec.kind = KIND_EXT_CAP;
            IDX_SECTOR_FMT:                      dec.kind = KIND_SECTOR_FMT;
            IDX_LSIZE_LO:                        dec.kind = KIND_LSIZE_LO;
            IDX_LSIZE_HI:                        dec.kind = KIND_LSIZE_HI;
            IDX_DONE:                            dec.kind = KIND_DONE;
            default:                             dec.kind = KIND_OTHER;
        endcase

        str_offset = word_index - str_base;
        pos        = {str_offset[4:0], 1'b0};

        if (dec.string_id != STR_NONE)
        begin
            dec.char_position = pos;
            if (lo_char != SPACE_CHAR)
                dec.cand_len = pos + 6'd2;
            else if (hi_char != SPACE_CHAR)
                dec.cand_len = pos + 6'd1;
            else
                dec.cand_len = '0;
        end
    end

endmodule
